FILE: hdl/rpb_pkg.sv
// Package for the RGB555 pixel blend unit: register indexes, modes, lane operations, masks.
package rpb_pkg;

    localparam int unsigned PIX_W  = 16;
    localparam int unsigned CHAN_W = 5;
    localparam int unsigned NUM_CH = 3;
    localparam int unsigned SHIFT_W = 3;
    localparam int unsigned CFG_ADDR_W = 2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_BLEND_MODE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BLEND_COLOR = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DIM_SHIFT   = 2'd2;

    // Masks for the averaging trick: upper three bits of each channel, low two bits, carry bits
    localparam logic [PIX_W-1:0] AVG_HI_MASK    = 16'h739c;
    localparam logic [PIX_W-1:0] AVG_LO_MASK    = 16'h0c63;
    localparam logic [PIX_W-1:0] AVG_CARRY_MASK = 16'h18c6;
    localparam logic [PIX_W-1:0] RGB_MASK       = 16'h7fff;

    typedef enum logic [2:0] {
        MODE_FILL     = 3'd0,
        MODE_AVERAGE  = 3'd1,
        MODE_ADD      = 3'd2,
        MODE_ADD_DIMC = 3'd3,
        MODE_ADD_DIMD = 3'd4,
        MODE_SUB      = 3'd5,
        MODE_PASS_A   = 3'd6,
        MODE_PASS_B   = 3'd7
    } blend_mode_t;

    typedef enum logic [1:0] {
        LANE_ADD      = 2'd0,
        LANE_ADD_DIMC = 2'd1,
        LANE_ADD_DIMD = 2'd2,
        LANE_SUB      = 2'd3
    } lane_op_t;

endpackage

FILE: hdl/rpb_lane.sv
// One 5-bit color channel: saturating add, add with a dimmed operand, or clamped subtract.
module rpb_lane (
    input  rpb_pkg::lane_op_t               op,
    input  logic [rpb_pkg::SHIFT_W-1:0]     shift,
    input  logic [rpb_pkg::CHAN_W-1:0]      dest,
    input  logic [rpb_pkg::CHAN_W-1:0]      color,
    output logic [rpb_pkg::CHAN_W-1:0]      result
);

    logic [rpb_pkg::CHAN_W-1:0] x;
    logic [rpb_pkg::CHAN_W-1:0] y;
    logic [rpb_pkg::CHAN_W:0]   sum;

    // shifts of 5 or more clear the shifted operand
    assign x   = (op == rpb_pkg::LANE_ADD_DIMD) ? (dest >> shift) : dest;
    assign y   = (op == rpb_pkg::LANE_ADD_DIMC) ? (color >> shift) : color;
    assign sum = {1'b0, x} + {1'b0, y};

    always_comb begin
        if (op == rpb_pkg::LANE_SUB) begin
            result = (x >= y) ? (x - y) : '0;
        end else if (sum[rpb_pkg::CHAN_W]) begin
            result = '1;
        end else begin
            result = sum[rpb_pkg::CHAN_W-1:0];
        end
    end

endmodule

FILE: hdl/rgb555_pixel_blend_unit.sv
// Top level of the RGB555 pixel blend unit: stream ports, configuration, two-stage pipeline.
//
// The unit blends a stream of RGB555 destination pixels (red bits 0-4, green 5-9, blue
// 10-14) with a configured color. blend_mode selects fill (the color word, all 16 bits),
// average (truncated per-channel mean), add (per-channel sum clamped at 31), add with
// the color channels shifted right by dim_shift, add with the destination channels shifted
// right by dim_shift, or subtract (destination minus color, clamped at 0). Modes 6 and 7
// pass the pixel through unchanged. Bit 15 of the result is zero in every mode except
// fill and the pass-through modes. Throughput is one pixel per clock while the output
// is not stalled; a pixel passes the input register and then the result register, with
// the blend logic between them, before appearing on m_tvalid. s_tready follows the
// pipeline occupancy and m_tready. Configuration writes (cfg_we, cfg_addr, cfg_wdata) take
// effect the next clock and must be done while no pixel is in flight; indexes above 2
// are ignored.
module rgb555_pixel_blend_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [rpb_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [rpb_pkg::PIX_W-1:0]         cfg_wdata,
    // input pixel stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rpb_pkg::PIX_W-1:0]         s_tdata,   // [15:0] dest_pixel
    // blended pixel stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rpb_pkg::PIX_W-1:0]         m_tdata    // [15:0] blended_pixel
);

    // configuration registers
    rpb_pkg::blend_mode_t               blend_mode_reg;
    logic [rpb_pkg::PIX_W-1:0]          blend_color_reg;
    logic [rpb_pkg::SHIFT_W-1:0]        dim_shift_reg;

    // pipeline registers
    logic                               in_valid_reg;
    logic [rpb_pkg::PIX_W-1:0]          in_data_reg;
    logic                               out_valid_reg;
    logic [rpb_pkg::PIX_W-1:0]          out_data_reg;
    logic [rpb_pkg::PIX_W-1:0]          out_data_next;

    logic                               out_load;
    logic                               in_load;

    // blend datapath
    rpb_pkg::lane_op_t                  lane_op;
    logic [rpb_pkg::PIX_W-1:0]          lane_pix;
    logic [rpb_pkg::PIX_W:0]            avg_hi;
    logic [rpb_pkg::PIX_W:0]            avg_lo;
    logic [rpb_pkg::PIX_W:0]            avg_sum;
    logic [rpb_pkg::PIX_W-1:0]          avg_pix;

    // Result stage loads from a full input stage when it is empty or its transaction completes this cycle;
    // the input stage may then refill in the same cycle.
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;
    assign in_load  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blend_mode_reg  <= rpb_pkg::MODE_FILL;
            blend_color_reg <= '0;
            dim_shift_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                rpb_pkg::REG_BLEND_MODE: begin
                    blend_mode_reg <= rpb_pkg::blend_mode_t'(cfg_wdata[2:0]);
                end
                rpb_pkg::REG_BLEND_COLOR: begin
                    blend_color_reg <= cfg_wdata;
                end
                rpb_pkg::REG_DIM_SHIFT: begin
                    dim_shift_reg <= cfg_wdata[rpb_pkg::SHIFT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_load) begin
                in_valid_reg <= 1'b1;
            end else if (out_load) begin
                in_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_data_reg <= s_tdata;
        end
        if (out_load) begin
            out_data_reg <= out_data_next;
        end
    end

    // Average: add the upper three bits of each channel separately from the low bits,
    // carry the low-bit sum into place, then halve.
    assign avg_hi  = {1'b0, in_data_reg & rpb_pkg::AVG_HI_MASK}
                   + {1'b0, blend_color_reg & rpb_pkg::AVG_HI_MASK};
    assign avg_lo  = {1'b0, in_data_reg & rpb_pkg::AVG_LO_MASK}
                   + {1'b0, blend_color_reg & rpb_pkg::AVG_LO_MASK};
    assign avg_sum = avg_hi + (avg_lo & {1'b0, rpb_pkg::AVG_CARRY_MASK});
    assign avg_pix = avg_sum[rpb_pkg::PIX_W:1] & rpb_pkg::RGB_MASK;

    always_comb begin
        case (blend_mode_reg)
            rpb_pkg::MODE_ADD_DIMC: lane_op = rpb_pkg::LANE_ADD_DIMC;
            rpb_pkg::MODE_ADD_DIMD: lane_op = rpb_pkg::LANE_ADD_DIMD;
            rpb_pkg::MODE_SUB:      lane_op = rpb_pkg::LANE_SUB;
            default:                lane_op = rpb_pkg::LANE_ADD;
        endcase
    end

    // three channel lanes; bit 15 of the lane result is always clear
    assign lane_pix[rpb_pkg::PIX_W-1] = 1'b0;

    for (genvar k = 0; k < rpb_pkg::NUM_CH; k++) begin : g_lane
        rpb_lane u_lane (
            .op     (lane_op),
            .shift  (dim_shift_reg),
            .dest   (in_data_reg[k*rpb_pkg::CHAN_W +: rpb_pkg::CHAN_W]),
            .color  (blend_color_reg[k*rpb_pkg::CHAN_W +: rpb_pkg::CHAN_W]),
            .result (lane_pix[k*rpb_pkg::CHAN_W +: rpb_pkg::CHAN_W])
        );
    end

    always_comb begin
        case (blend_mode_reg)
            rpb_pkg::MODE_FILL:     out_data_next = blend_color_reg;
            rpb_pkg::MODE_AVERAGE:  out_data_next = avg_pix;
            rpb_pkg::MODE_ADD,
            rpb_pkg::MODE_ADD_DIMC,
            rpb_pkg::MODE_ADD_DIMD,
            rpb_pkg::MODE_SUB:      out_data_next = lane_pix;
            default:                out_data_next = in_data_reg;
        endcase
    end

`ifndef SYNTHESIS
    // no result is pending in the cycle after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // with both stages full and the output stalled, no new transaction may enter
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while pipeline is full");

    // lane and average modes never set bit 15
    a_bit15_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (blend_mode_reg == rpb_pkg::MODE_AVERAGE
            || blend_mode_reg == rpb_pkg::MODE_ADD
            || blend_mode_reg == rpb_pkg::MODE_ADD_DIMC
            || blend_mode_reg == rpb_pkg::MODE_ADD_DIMD
            || blend_mode_reg == rpb_pkg::MODE_SUB)) |=> !m_tdata[15])
        else $error("bit 15 set in a blend result");
`endif

endmodule
